>>> hw/rtl/skl_pkg.sv
// Shared types and constants for the sorted key list.
`timescale 1ns / 1ps

package skl_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 32;

  // Operation codes on the input transaction.
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;
  localparam logic [1:0] FUNC_DUMP   = 2'd3;

  // Status codes on the result transaction.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [KEY_W-1:0] key;
  } skl_in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic [1:0]              status;
    logic                    last;
  } skl_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_DUMP
  } skl_state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } skl_cell_op_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    skl_cell_op_t            op;
    logic                    cmp_en;
    logic                    found;
    logic signed [KEY_W-1:0] key;
  } skl_cell_ctl_t;

  // Status a cell reports back from its registered compare.
  typedef struct packed {
    logic ahead;
    logic match;
  } skl_cell_flags_t;

endpackage

>>> hw/rtl/skl_cell.sv
// One cell of the key chain: holds a key, compares it and shifts with its neighbours.
`timescale 1ns / 1ps

module skl_cell (
  input  logic                                  clk,
  input  skl_pkg::skl_cell_ctl_t                ctl,
  input  logic                                  occ,
  input  logic                                  prev_ahead,
  input  logic signed [skl_pkg::KEY_W-1:0]      left_key,
  input  logic signed [skl_pkg::KEY_W-1:0]      right_key,
  output logic signed [skl_pkg::KEY_W-1:0]      key_q,
  output skl_pkg::skl_cell_flags_t              flags
);

  logic signed [skl_pkg::KEY_W-1:0] key_r;
  logic                             le_r;
  logic                             lt_r;
  logic                             eq_r;
  logic                             ahead;

  // Compare against the incoming key when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      le_r <= key_r <= ctl.key;
      lt_r <= key_r <  ctl.key;
      eq_r <= key_r == ctl.key;
    end
  end

  // An occupied cell whose key is not above the new key stays in front of it.
  assign ahead = occ & le_r;

  // Key update: open a gap for insert, close one for remove, or rotate for a dump.
  always_ff @(posedge clk) begin
    case (ctl.op)
      skl_pkg::OP_INSERT: begin
        if (!ahead) begin
          key_r <= prev_ahead ? ctl.key : left_key;
        end
      end
      skl_pkg::OP_REMOVE: begin
        if (ctl.found && occ && !lt_r) begin
          key_r <= right_key;
        end
      end
      skl_pkg::OP_ROTATE: begin
        key_r <= right_key;
      end
      default: begin
        key_r <= key_r;
      end
    endcase
  end

  assign key_q       = key_r;
  assign flags.ahead = ahead;
  assign flags.match = occ & eq_r;

endmodule

>>> hw/rtl/sorted_key_list.sv
// Top level of the sorted key list: control, entry count and the chain of cells.
//
//   channel | direction | payload    | handshake
//   in      | input     | skl_in_t   | in_valid / in_stall
//   out     | output    | skl_out_t  | out_valid / out_stall
//
// Insert, remove and search compare on the accept edge, then shift the chain where needed
// and register the result in S_APPLY, which waits while a result is stalled.
// A dump checks the count in S_APPLY, then in S_DUMP rotates the chain a full turn,
// emitting one key a cycle from its head; stalls hold the rotation.
// Reset empties the list; the stored keys are not cleared.
// One transaction is in work at a time; a new one is taken while a result waits.
`timescale 1ns / 1ps

module sorted_key_list #(
  parameter int CAPACITY = skl_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  skl_pkg::skl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output skl_pkg::skl_out_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  skl_pkg::skl_state_t               state_r, state_nxt;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [CW-1:0]                     step_r, step_nxt;
  logic [1:0]                        func_r;
  logic signed [skl_pkg::KEY_W-1:0]  key_r;
  logic                              out_valid_r, out_valid_nxt;
  skl_pkg::skl_out_t                 out_data_r, out_data_nxt;
  skl_pkg::skl_cell_ctl_t            ctl;
  skl_pkg::skl_cell_op_t             op;
  logic                              accept;
  logic                              out_free;
  logic                              found;
  logic                              full;
  logic                              emit;

  logic signed [skl_pkg::KEY_W-1:0]  cell_key [CAPACITY];
  skl_pkg::skl_cell_flags_t          cell_flags [CAPACITY];
  logic [CAPACITY-1:0]               match_vec;

  assign accept   = in_valid & ~in_stall;
  assign in_stall = (state_r != skl_pkg::S_IDLE);
  assign out_free = ~out_valid_r | ~out_stall;
  assign full     = (count_r == CW'(CAPACITY));
  assign found    = |match_vec;
  assign emit     = (step_r < count_r);

  // Chain of cells; the head feeds the dump output.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic occ;
    logic prev_ahead;
    logic signed [skl_pkg::KEY_W-1:0] left_key;
    logic signed [skl_pkg::KEY_W-1:0] right_key;

    assign occ = (CW'(i) < count_r);

    if (i == 0) begin : g_head
      assign prev_ahead = 1'b1;
      assign left_key   = cell_key[0];
    end else begin : g_body
      assign prev_ahead = cell_flags[i-1].ahead;
      assign left_key   = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = cell_key[0];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    skl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ),
      .prev_ahead (prev_ahead),
      .left_key   (left_key),
      .right_key  (right_key),
      .key_q      (cell_key[i]),
      .flags      (cell_flags[i])
    );

    assign match_vec[i] = cell_flags[i].match;
  end

  // Broadcast control to the cells.
  always_comb begin
    ctl.op     = op;
    ctl.cmp_en = accept;
    ctl.found  = found;
    ctl.key    = (state_r == skl_pkg::S_IDLE) ? in_data.key : key_r;
  end

  // Next state, cell operation and result.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    op            = skl_pkg::OP_HOLD;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      skl_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = skl_pkg::S_APPLY;
        end
      end
      skl_pkg::S_APPLY: begin
        if (func_r == skl_pkg::FUNC_DUMP) begin
          step_nxt  = '0;
          state_nxt = (count_r == '0) ? skl_pkg::S_IDLE : skl_pkg::S_DUMP;
        end else if (out_free) begin
          state_nxt            = skl_pkg::S_IDLE;
          out_valid_nxt        = 1'b1;
          out_data_nxt.key_out = key_r;
          out_data_nxt.last    = 1'b1;
          out_data_nxt.status  = skl_pkg::ST_OK;
          case (func_r)
            skl_pkg::FUNC_INSERT: begin
              if (full) begin
                out_data_nxt.status = skl_pkg::ST_FULL;
              end else begin
                op        = skl_pkg::OP_INSERT;
                count_nxt = count_r + CW'(1);
              end
            end
            skl_pkg::FUNC_REMOVE: begin
              if (found) begin
                op        = skl_pkg::OP_REMOVE;
                count_nxt = count_r - CW'(1);
              end else begin
                out_data_nxt.status = skl_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              if (!found) begin
                out_data_nxt.status = skl_pkg::ST_NOT_FOUND;
              end
            end
          endcase
        end
      end
      skl_pkg::S_DUMP: begin
        if (!emit || out_free) begin
          op       = skl_pkg::OP_ROTATE;
          step_nxt = step_r + CW'(1);
          if (emit) begin
            out_valid_nxt        = 1'b1;
            out_data_nxt.key_out = cell_key[0];
            out_data_nxt.status  = skl_pkg::ST_OK;
            out_data_nxt.last    = (step_r + CW'(1) == count_r);
          end
          if (step_r == CW'(CAPACITY - 1)) begin
            state_nxt = skl_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = skl_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skl_pkg::S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Captured transaction and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_data.func;
      key_r  <= in_data.key;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // The entry count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // The entry count only moves on the update cycle of a transaction.
  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      ($past(state_r) == skl_pkg::S_APPLY))
    else $error("entry count changed outside an update");

  // A new result is only loaded from the update or dump states.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |->
      ($past(state_r) == skl_pkg::S_APPLY || $past(state_r) == skl_pkg::S_DUMP))
    else $error("result appeared without an operation");
`endif

endmodule

>>> tb/sorted_key_list_checker.sv
// Checker for the sorted key list: predicts every result and compares it on the output channel.
`timescale 1ns / 1ps

module sorted_key_list_checker #(
  parameter int CAPACITY = skl_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  skl_pkg::skl_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  skl_pkg::skl_out_t out_data,
  output int                fail_count,
  output int                pending,
  output int                results_seen
);

  // Our own copy of the list contents and the results still owed by the block.
  logic signed [skl_pkg::KEY_W-1:0] shelf [CAPACITY];
  int                               held = 0;
  skl_pkg::skl_out_t                owed_q [$];
  int                               errs = 0;
  int                               seen = 0;

  task automatic owe_result(input logic signed [skl_pkg::KEY_W-1:0] k,
                            input logic [1:0] st, input logic lst);
    skl_pkg::skl_out_t r;
    r.key_out = k;
    r.status  = st;
    r.last    = lst;
    owed_q.push_back(r);
  endtask

  // Position of the first stored key that is not below k, or the fill level.
  function automatic int first_not_below(input logic signed [skl_pkg::KEY_W-1:0] k);
    int pos;
    pos = 0;
    while (pos < held && shelf[pos] < k) pos++;
    return pos;
  endfunction

  // Applies one accepted transaction to the list and records what it must produce.
  task automatic apply_op(input skl_pkg::skl_in_t t);
    logic signed [skl_pkg::KEY_W-1:0] k;
    int pos;
    int i;
    k = t.key;
    case (t.func)
      skl_pkg::FUNC_INSERT: begin
        if (held >= CAPACITY) begin
          owe_result(k, skl_pkg::ST_FULL, 1'b1);
        end else begin
          // New key goes after every key that is equal or smaller.
          pos = 0;
          while (pos < held && shelf[pos] <= k) pos++;
          for (i = held; i > pos; i--) shelf[i] = shelf[i-1];
          shelf[pos] = k;
          held++;
          owe_result(k, skl_pkg::ST_OK, 1'b1);
        end
      end
      skl_pkg::FUNC_REMOVE: begin
        pos = first_not_below(k);
        if (pos < held && shelf[pos] == k) begin
          for (i = pos; i + 1 < held; i++) shelf[i] = shelf[i+1];
          held--;
          owe_result(k, skl_pkg::ST_OK, 1'b1);
        end else begin
          owe_result(k, skl_pkg::ST_NOT_FOUND, 1'b1);
        end
      end
      skl_pkg::FUNC_SEARCH: begin
        pos = first_not_below(k);
        owe_result(k, (pos < held && shelf[pos] == k) ? skl_pkg::ST_OK :
                      skl_pkg::ST_NOT_FOUND, 1'b1);
      end
      default: begin
        // A dump of an empty list owes nothing.
        for (i = 0; i < held; i++) owe_result(shelf[i], skl_pkg::ST_OK, i + 1 == held);
      end
    endcase
  endtask

  task automatic report(input string msg);
    errs++;
    if (errs <= 10) $display("%s", msg);
  endtask

  // Results are checked before the same edge's input is predicted, so a
  // stray result can never be matched against an expectation made at that edge.
  always @(posedge clk) begin
    skl_pkg::skl_out_t want;
    if (!rst_n) begin
      held = 0;
      owed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen++;
        if (owed_q.size() == 0) begin
          report($sformatf("Unexpected result: key %0d status %0d last %0d",
                           $signed(out_data.key_out), out_data.status, out_data.last));
        end else begin
          want = owed_q.pop_front();
          if (out_data.key_out !== want.key_out || out_data.status !== want.status ||
              out_data.last !== want.last) begin
            report($sformatf({"Mismatch on result %0d: expected key %0d status %0d last %0d,",
                              " got key %0d status %0d last %0d"}, seen,
                             $signed(want.key_out), want.status, want.last,
                             $signed(out_data.key_out), out_data.status, out_data.last));
          end
        end
      end
      if (in_valid && !in_stall) apply_op(in_data);
    end
    fail_count   <= errs;
    pending      <= owed_q.size();
    results_seen <= seen;
  end

endmodule

>>> tb/sorted_key_list_tb.sv
// Testbench top for the sorted key list: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module sorted_key_list_tb;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int RAND_ITEMS  = 344;
  localparam int PHASE_LEN   = 43;
  localparam int CALM_TAIL   = 60;
  localparam int HIST_DEPTH  = 24;

  localparam logic signed [skl_pkg::KEY_W-1:0] KEY_MAX =
    {1'b0, {(skl_pkg::KEY_W-1){1'b1}}};
  localparam logic signed [skl_pkg::KEY_W-1:0] KEY_MIN =
    {1'b1, {(skl_pkg::KEY_W-1){1'b0}}};

  // Random phases: fill the list, churn it, drain it.
  localparam int MODE_FILL  = 0;
  localparam int MODE_MIXED = 1;
  localparam int MODE_DRAIN = 2;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  skl_pkg::skl_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  skl_pkg::skl_out_t out_data;

  int  fail_count;
  int  pending;
  int  results_seen;
  bit  idle_off   = 1'b0;
  int  stall_left = 0;
  int  cycle_cnt  = 0;
  int  op_count [4] = '{0, 0, 0, 0};
  logic signed [skl_pkg::KEY_W-1:0] recent_keys [$];

  initial begin
    forever #5 clk = ~clk;
  end

  sorted_key_list i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sorted_key_list_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // Receiver back-pressure in random bursts.
  always @(posedge clk) begin
    if (!rst_n || idle_off) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding",
               cycle_cnt, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Presents one transaction, optionally after a gap, and holds it until accepted.
  // Valid stays high after acceptance so back-to-back transactions need no toggle.
  task automatic send_item(input logic [1:0] f,
                           input logic signed [skl_pkg::KEY_W-1:0] k,
                           input bit calm);
    skl_pkg::skl_in_t t;
    int gap;
    t.func = f;
    t.key  = k;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    op_count[f]++;
    if (f == skl_pkg::FUNC_INSERT) begin
      recent_keys.push_back(k);
      if (recent_keys.size() > HIST_DEPTH) void'(recent_keys.pop_front());
    end
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Keys that collide, the extremes and fully random values, in equal shares.
  function automatic logic signed [skl_pkg::KEY_W-1:0] pick_key();
    int v;
    case ($urandom_range(0, 11))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2:       return KEY_MIN + 1;
      3:       return KEY_MAX - 1;
      4, 5, 6, 7: begin
        v = $urandom_range(0, 6);
        return v - 3;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_func(input int mode);
    int r;
    int ins_pct;
    int rem_pct;
    r       = $urandom_range(0, 99);
    ins_pct = (mode == MODE_FILL) ? 70 : (mode == MODE_DRAIN) ? 10 : 35;
    rem_pct = (mode == MODE_FILL) ? 10 : (mode == MODE_DRAIN) ? 70 : 30;
    if (r < ins_pct) return skl_pkg::FUNC_INSERT;
    if (r < ins_pct + rem_pct) return skl_pkg::FUNC_REMOVE;
    if (r < 92) return skl_pkg::FUNC_SEARCH;
    return skl_pkg::FUNC_DUMP;
  endfunction

  initial begin
    int n;
    int i;
    int mode;
    bit calm;
    bit use_hist;
    logic [1:0] f;
    logic signed [skl_pkg::KEY_W-1:0] k;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list cases, extremes, duplicates, then fill past capacity.
    send_item(skl_pkg::FUNC_DUMP, 0, 1'b0);
    send_item(skl_pkg::FUNC_SEARCH, 0, 1'b0);
    send_item(skl_pkg::FUNC_REMOVE, 7, 1'b0);
    send_item(skl_pkg::FUNC_INSERT, KEY_MAX, 1'b0);
    send_item(skl_pkg::FUNC_INSERT, KEY_MIN, 1'b0);
    send_item(skl_pkg::FUNC_INSERT, 0, 1'b0);
    send_item(skl_pkg::FUNC_INSERT, 0, 1'b0);
    send_item(skl_pkg::FUNC_INSERT, -1, 1'b0);
    send_item(skl_pkg::FUNC_SEARCH, KEY_MIN, 1'b0);
    send_item(skl_pkg::FUNC_REMOVE, 0, 1'b0);
    send_item(skl_pkg::FUNC_REMOVE, KEY_MAX, 1'b0);
    for (i = 0; i < 13; i++) begin
      k = (i % 2 != 0) ? i * 1000 : -i * 997;
      send_item(skl_pkg::FUNC_INSERT, k, 1'b0);
    end
    send_item(skl_pkg::FUNC_INSERT, 5, 1'b0);
    send_item(skl_pkg::FUNC_DUMP, $urandom, 1'b0);
    wait_drained();

    // Random phases; the tail of the run has no idling on either side.
    calm = 1'b0;
    mode = MODE_FILL;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ((n / PHASE_LEN) % 4)
          0:       mode = MODE_FILL;
          2:       mode = MODE_DRAIN;
          default: mode = MODE_MIXED;
        endcase
        calm = ($urandom_range(0, 4) == 0);
      end
      if (n >= RAND_ITEMS - CALM_TAIL) calm = 1'b1;
      idle_off <= calm;
      if (n == RAND_ITEMS / 2) wait_drained();
      f = pick_func(mode);
      use_hist = (f == skl_pkg::FUNC_REMOVE) ? ($urandom_range(0, 3) != 0) :
                 (f == skl_pkg::FUNC_SEARCH) ? ($urandom_range(0, 1) != 0) : 1'b0;
      if (use_hist && recent_keys.size() != 0)
        k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      else
        k = pick_key();
      send_item(f, k, calm);
    end

    // Let everything owed come back, then allow for a full dump's worth of cycles.
    wait_drained();
    repeat (skl_pkg::CAPACITY_DEF + 8) @(posedge clk);

    $display("Covered %0d inserts, %0d removes, %0d searches and %0d dumps;",
             op_count[skl_pkg::FUNC_INSERT], op_count[skl_pkg::FUNC_REMOVE],
             op_count[skl_pkg::FUNC_SEARCH], op_count[skl_pkg::FUNC_DUMP]);
    $display("%0d results checked.", results_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures recorded", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
